/* rtl/ptt_pkg.sv */
// Shared types and codes for the periodic timer table.
// No dependencies; every other rtl file refers to it by scoped names.
package ptt_pkg;

	localparam int TIME_W = 48;
	localparam int PER_W  = 31;
	localparam int QDEPTH = 2;

	// request codes on req_type
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_ADD  = 2'd1;
	localparam logic [1:0] REQ_DEL  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_DELETED = 3'd1;
	localparam logic [2:0] ST_FIRED   = 3'd2;
	localparam logic [2:0] ST_DONE    = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_BADSLOT = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ADD,
		OP_DEL
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [TIME_W-1:0]  now;
		logic [3:0]         slot;
		logic [PER_W-1:0]   delay;
		logic [PER_W-1:0]   period;
	} cmd_t;

endpackage

/* rtl/ptt_if.sv */
// Valid/ready channel interfaces for the timer table request and result items.
// Depends on ptt_pkg for field widths.
interface ptt_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [ptt_pkg::TIME_W-1:0]   now_ms;
	logic [3:0]                   slot;
	logic [ptt_pkg::PER_W-1:0]    start_ms;
	logic [ptt_pkg::PER_W-1:0]    reload_ms;

	modport source (output valid, req_type, now_ms, slot, start_ms, reload_ms, input ready);
	modport sink   (input valid, req_type, now_ms, slot, start_ms, reload_ms, output ready);
endinterface

interface ptt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] slot_out;
	logic       last;

	modport source (output valid, status, slot_out, last, input ready);
	modport sink   (input valid, status, slot_out, last, output ready);
endinterface

/* rtl/ptt_front.sv */
// Front end: accepts request items, decodes them into commands for the queue.
// Depends on ptt_pkg and ptt_if.
module ptt_front (
	ptt_in_if.sink          req,
	input  logic            q_full,
	output logic            push,
	output ptt_pkg::cmd_t   push_cmd
);

	logic known;

	assign req.ready = !q_full;

	always_comb begin
		known           = 1'b1;
		push_cmd.op     = ptt_pkg::OP_TICK;
		push_cmd.now    = req.now_ms;
		push_cmd.slot   = req.slot;
		push_cmd.delay  = req.start_ms;
		push_cmd.period = req.reload_ms;
		case (req.req_type)
			ptt_pkg::REQ_TICK: push_cmd.op = ptt_pkg::OP_TICK;
			ptt_pkg::REQ_ADD:  push_cmd.op = ptt_pkg::OP_ADD;
			ptt_pkg::REQ_DEL:  push_cmd.op = ptt_pkg::OP_DEL;
			default:           known = 1'b0;  // unknown request: dropped, no result
		endcase
	end

	assign push = req.valid && !q_full && known;

endmodule

/* rtl/ptt_queue.sv */
// Short command queue between the front end and the executor.
// Depends on ptt_pkg.
module ptt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ptt_pkg::cmd_t   push_cmd,
	output logic            full,
	input  logic            pop,
	output ptt_pkg::cmd_t   pop_cmd,
	output logic            empty
);

	localparam int PW = (ptt_pkg::QDEPTH > 1) ? $clog2(ptt_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(ptt_pkg::QDEPTH + 1);

	ptt_pkg::cmd_t   entry_q [ptt_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(ptt_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(ptt_pkg::QDEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(ptt_pkg::QDEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/ptt_back.sv */
// Executor: holds the timer table, runs add, delete and tick scans, drives results.
// Depends on ptt_pkg and ptt_if.
module ptt_back #(
	parameter int SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  ptt_pkg::cmd_t   cmd,
	output logic            pop,
	ptt_out_if.source       rsp
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DONE
	} bk_state_t;

	bk_state_t                   state_q;
	logic [SW-1:0]               idx_q;
	logic [ptt_pkg::TIME_W-1:0]  now_q;
	logic [SLOTS-1:0]            valid_q;
	logic                        out_valid_q;
	logic [2:0]                  out_status_q;
	logic [3:0]                  out_slot_q;
	logic                        out_last_q;

	logic [ptt_pkg::TIME_W-1:0]  exp_mem [SLOTS];
	logic [ptt_pkg::PER_W-1:0]   per_mem [SLOTS];
	logic [ptt_pkg::TIME_W-1:0]  rd_exp_q;
	logic [ptt_pkg::PER_W-1:0]   rd_per_q;

	logic                        out_free;
	logic                        free_any;
	logic [SW-1:0]               free_idx;
	logic [6:0]                  slot_ext;
	logic [SW-1:0]               del_idx;
	logic                        del_ok;
	logic                        fire;
	logic                        scan_adv;
	logic                        rd_en;
	logic [SW-1:0]               rd_addr;
	logic                        exp_we;
	logic                        per_we;
	logic [SW-1:0]               wr_addr;
	logic [ptt_pkg::TIME_W-1:0]  wr_exp;

	assign out_free = !out_valid_q || rsp.ready;
	assign pop      = (state_q == BK_IDLE) && !empty && out_free;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign slot_ext = {3'b000, cmd.slot};
	assign del_idx  = slot_ext[SW-1:0];
	assign del_ok   = (slot_ext < 7'(SLOTS)) && valid_q[del_idx];

	assign fire     = valid_q[idx_q] && (rd_exp_q <= now_q);
	assign scan_adv = (state_q == BK_SCAN) && (!fire || out_free);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (pop && cmd.op == ptt_pkg::OP_TICK) begin
			rd_en = 1'b1;
		end else if (scan_adv && idx_q != LAST) begin
			rd_en   = 1'b1;
			rd_addr = SW'(idx_q + 1'b1);
		end
	end

	always_comb begin
		per_we  = pop && (cmd.op == ptt_pkg::OP_ADD) && free_any;
		exp_we  = per_we || (scan_adv && fire);
		wr_addr = (state_q == BK_SCAN) ? idx_q : free_idx;
		wr_exp  = (state_q == BK_SCAN)
			? ptt_pkg::TIME_W'(rd_exp_q + {{(ptt_pkg::TIME_W - ptt_pkg::PER_W){1'b0}}, rd_per_q})
			: ptt_pkg::TIME_W'(cmd.now + {{(ptt_pkg::TIME_W - ptt_pkg::PER_W){1'b0}}, cmd.delay});
	end

	// expiry and period storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[wr_addr] <= wr_exp;
		end
		if (per_we) begin
			per_mem[wr_addr] <= cmd.period;
		end
		if (rd_en) begin
			rd_exp_q <= exp_mem[rd_addr];
			rd_per_q <= per_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			idx_q        <= '0;
			now_q        <= '0;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_slot_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						case (cmd.op)
							ptt_pkg::OP_ADD: begin
								out_valid_q <= 1'b1;
								out_last_q  <= 1'b1;
								if (free_any) begin
									valid_q[free_idx] <= 1'b1;
									out_status_q      <= ptt_pkg::ST_ADDED;
									out_slot_q        <= 4'(free_idx);
								end else begin
									out_status_q <= ptt_pkg::ST_FULL;
									out_slot_q   <= '0;
								end
							end
							ptt_pkg::OP_DEL: begin
								out_valid_q <= 1'b1;
								out_last_q  <= 1'b1;
								if (del_ok) begin
									valid_q[del_idx] <= 1'b0;
									out_status_q     <= ptt_pkg::ST_DELETED;
									out_slot_q       <= cmd.slot;
								end else begin
									out_status_q <= ptt_pkg::ST_BADSLOT;
									out_slot_q   <= '0;
								end
							end
							ptt_pkg::OP_TICK: begin
								idx_q   <= '0;
								now_q   <= cmd.now;
								state_q <= BK_SCAN;
							end
							default: ;
						endcase
					end
				end
				BK_SCAN: begin
					if (scan_adv) begin
						if (fire) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ptt_pkg::ST_FIRED;
							out_slot_q   <= 4'(idx_q);
							out_last_q   <= 1'b0;
						end
						if (idx_q == LAST) begin
							state_q <= BK_DONE;
						end else begin
							idx_q <= SW'(idx_q + 1'b1);
						end
					end
				end
				BK_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ptt_pkg::ST_DONE;
						out_slot_q   <= '0;
						out_last_q   <= 1'b1;
						state_q      <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.slot_out = out_slot_q;
	assign rsp.last     = out_last_q;

endmodule

/* rtl/periodic_task_timer_table.sv */
// Top level of the periodic timer table: front end, command queue, executor.
// Depends on ptt_pkg, ptt_if, ptt_front, ptt_queue and ptt_back.
//
// Usage:
//   req carries one request item per handshake: tick, add or delete, each
//   stamped with the current time now_ms. rsp carries result items; the
//   final result of each request has last set. Request type 3 is dropped
//   without any result.
// Result path: an add or delete result is registered in the output register
//   after its request passes through the queue and is popped by the executor,
//   if the queue is empty and the result side is free. A tick's done result
//   follows the scan of all SLOTS slots and the done state.
// Executor: add and delete are completed in the idle state as soon as they
//   are popped. A tick leaves the idle state, then the scan walks the
//   expiry/period memory through its single read port, one slot per cycle
//   while the result side is free, then the done state gives the done result.
//   Requests keep being accepted into a two-entry queue while the executor works.
// Reset: arst_n clears all slot valid bits (no timers), the queue and the
//   output register. Expiry and period storage is not cleared; it is read
//   during a scan but only acted on for valid slots.
// Stall: when rsp.ready is low the result stays in the output register, the
//   executor pauses on its next result and the queue fills, after which
//   req.ready drops.
module periodic_task_timer_table #(
	parameter int SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ptt_in_if.sink     req,
	ptt_out_if.source  rsp
);

	logic           push;
	logic           q_full;
	logic           q_empty;
	logic           pop;
	ptt_pkg::cmd_t  push_cmd;
	ptt_pkg::cmd_t  pop_cmd;

	ptt_front u_front (
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ptt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	ptt_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.cmd    (pop_cmd),
		.pop    (pop),
		.rsp    (rsp)
	);

	// front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command pushed into full queue");

	// executor never takes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command popped from empty queue");

	// fired results never close a request; every other result does
	a_last_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.status == ptt_pkg::ST_FIRED) == !rsp.last))
		else $error("last flag does not match result status");

	// a done result always carries slot zero
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ptt_pkg::ST_DONE) |-> (rsp.slot_out == 4'd0))
		else $error("done result with nonzero slot");

endmodule
